// ===== rtl/fnpa_pkg.sv =====
// ---------------------------------------------------------------------------
// fnpa_pkg: shared types and constants of the fixed node pool allocator
// Status codes, controller states, the command bundle and port widths.
// ---------------------------------------------------------------------------
package fnpa_pkg;

	// Default configuration of the pool
	localparam int DEF_POOL_DEPTH = 256;
	localparam int DEF_NODE_BYTES = 32;

	// Field widths
	localparam int POOL_CAP_W   = 9;
	localparam int OFFSET_W     = 32;
	localparam int REQ_TYPE_W   = 1;
	localparam int STATUS_W     = 3;
	localparam int NODE_INDEX_W = 8;
	localparam int FREE_COUNT_W = 9;

	// Stream widths
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 24;

	// Request kinds carried in tuser
	localparam logic REQ_LEASE   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_RANGE    = 3'd2,
		ST_MISALIGN = 3'd3,
		ST_FULL     = 3'd4
	} fnpa_status_t;

	typedef enum logic {
		CS_IDLE,
		CS_EXEC
	} fnpa_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic refill;  // capacity transaction accepted
		logic load;    // request transaction accepted
		logic commit;  // update state and load the result register
	} fnpa_cmd_t;

endpackage

// ===== rtl/fnpa_ram.sv =====
// ---------------------------------------------------------------------------
// fnpa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module fnpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, hold data when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/fnpa_ctrl.sv =====
// ---------------------------------------------------------------------------
// fnpa_ctrl: controller of the fixed node pool allocator
// Sequences accept and execute cycles and owns the output valid flag.
// ---------------------------------------------------------------------------
module fnpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output fnpa_pkg::fnpa_cmd_t cmd
);
	import fnpa_pkg::*;

	fnpa_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cfg_ready  = 1'b0;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			CS_IDLE: begin
				cfg_ready  = 1'b1;
				in_ready   = !cfg_valid;
				cmd.refill = cfg_valid;
				cmd.load   = in_valid && !cfg_valid;
				if (in_valid && !cfg_valid) begin
					state_d = CS_EXEC;
				end
			end
			CS_EXEC: begin
				// wait for room in the result register
				cmd.commit = out_free;
				if (out_free) begin
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	// Output valid: set on commit, drop once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/fnpa_dp.sv =====
// ---------------------------------------------------------------------------
// fnpa_dp: datapath of the fixed node pool allocator
// Free stack with its top entry in a register, offset checks and result.
// ---------------------------------------------------------------------------
module fnpa_dp #(
	parameter int POOL_DEPTH = 256,
	parameter int NODE_BYTES = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fnpa_pkg::fnpa_cmd_t               cmd,
	input  logic [fnpa_pkg::POOL_CAP_W-1:0]   cfg_data,
	input  logic [fnpa_pkg::IN_TDATA_W-1:0]   in_data,
	input  logic [fnpa_pkg::IN_TUSER_W-1:0]   in_user,
	output logic [fnpa_pkg::OUT_TDATA_W-1:0]  out_data
);
	import fnpa_pkg::*;

	// Stack sizing: the capacity never exceeds 511
	localparam int STACK_DEPTH = (POOL_DEPTH < 512) ? POOL_DEPTH : 512;
	localparam int SIZE_MAX    = (POOL_DEPTH < 511) ? POOL_DEPTH : 511;
	localparam int RESET_SIZE  = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;
	localparam int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// Offset arithmetic: in-range offsets fit XW bits
	localparam int LOGNB = $clog2(NODE_BYTES);
	localparam int NBW   = $clog2(NODE_BYTES + 1);
	localparam int XW    = POOL_CAP_W + LOGNB;
	localparam int SH    = XW + LOGNB;
	localparam int MW    = XW + 2;
	localparam int PW    = XW + MW;
	localparam int QW    = POOL_CAP_W + 1;
	localparam int BW    = QW + NBW;
	localparam logic [63:0] RECIP64 =
		((64'd1 << SH) + 64'(NODE_BYTES) - 64'd1) / 64'(NODE_BYTES);
	localparam logic [MW-1:0]  RECIP = RECIP64[MW-1:0];
	localparam logic [NBW-1:0] NB_C  = NBW'(NODE_BYTES);
	localparam logic [POOL_CAP_W-1:0] RESET_SIZE_C = POOL_CAP_W'(RESET_SIZE);
	localparam logic [XW-1:0]  RESET_LIMIT = XW'(RESET_SIZE) * XW'(NODE_BYTES);
	localparam int PAD_W = OUT_TDATA_W - STATUS_W - NODE_INDEX_W - FREE_COUNT_W;

	// Pool state
	logic [POOL_CAP_W-1:0] pool_cap_q;
	logic [XW-1:0]         limit_q;
	logic [POOL_CAP_W-1:0] free_q;
	logic [POOL_CAP_W-1:0] min_q;    // lowest free count since refill
	logic [AW-1:0]         top_q;    // stack slot 0

	// Request stage
	logic                req_s1;
	logic [OFFSET_W-1:0] off_s1;
	logic [PW-1:0]       prod_s1;

	// Memory ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_rdata;
	logic [POOL_CAP_W-1:0] rd_pos;

	// Refill values
	logic [POOL_CAP_W-1:0] sat_size;
	logic [XW-1:0]         sat_limit;
	logic                  do_refill;

	// Execute logic
	logic [POOL_CAP_W-1:0] lease_ft;
	logic [XW-1:0]          x_val;
	logic [QW-1:0]          quot;
	logic [BW-1:0]          back;
	logic                   in_range;
	logic                   aligned;
	fnpa_status_t           status;
	logic [POOL_CAP_W-1:0]  free_d;
	logic [POOL_CAP_W-1:0]  min_d;
	logic [AW-1:0]          top_d;
	logic [15:0]            idx_wide;
	logic [NODE_INDEX_W-1:0] idx_out;

	// Saturate the written size, ignore zero
	assign do_refill = cmd.refill && (cfg_data != '0);
	assign sat_size  = ({1'b0, cfg_data} > 10'(SIZE_MAX)) ? POOL_CAP_W'(SIZE_MAX) : cfg_data;
	assign sat_limit = XW'(sat_size) * XW'(NODE_BYTES);

	// Read the entry that a lease moves into slot 0
	assign rd_pos = (free_q == '0) ? '0 : free_q - 1'b1;

	// Capture the request and start the quotient multiply
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_s1  <= in_user[0];
			off_s1  <= in_data;
			prod_s1 <= PW'(in_data[XW-1:0]) * PW'(RECIP);
		end
	end

	// Offset checks: quotient by reciprocal, alignment by multiply back
	assign x_val    = off_s1[XW-1:0];
	assign in_range = !off_s1[OFFSET_W-1] &&
	                  (off_s1[OFFSET_W-2:0] < (OFFSET_W-1)'(limit_q));
	assign quot     = prod_s1[SH +: QW];
	assign back     = BW'(quot) * BW'(NB_C);
	assign aligned  = (back == BW'(x_val));
	assign lease_ft = free_q - 1'b1;

	// Decide status and next stack state
	always_comb begin
		status    = ST_OK;
		free_d    = free_q;
		min_d     = min_q;
		top_d     = top_q;
		ram_we    = 1'b0;
		ram_waddr = free_q[AW-1:0];
		idx_wide  = '0;
		if (req_s1 == REQ_LEASE) begin
			if (free_q == '0) begin
				status = ST_EMPTY;
			end else begin
				idx_wide = 16'(top_q);
				free_d   = lease_ft;
				if (lease_ft < min_q) begin
					min_d = lease_ft;
				end
				// entries below the low mark were never written since refill
				if (lease_ft != '0) begin
					top_d = (lease_ft >= min_q) ? ram_rdata : lease_ft[AW-1:0];
				end
			end
		end else begin
			if (!in_range) begin
				status = ST_RANGE;
			end else if (!aligned) begin
				status = ST_MISALIGN;
			end else if (free_q >= pool_cap_q) begin
				status = ST_FULL;
			end else begin
				free_d = free_q + 1'b1;
				if (free_q == '0) begin
					top_d = quot[AW-1:0];
				end else begin
					ram_we = cmd.commit;
				end
			end
		end
	end

	assign idx_out = idx_wide[NODE_INDEX_W-1:0];

	// Pool state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_cap_q <= RESET_SIZE_C;
			limit_q    <= RESET_LIMIT;
			free_q     <= RESET_SIZE_C;
			min_q      <= RESET_SIZE_C;
			top_q      <= '0;
		end else if (do_refill) begin
			pool_cap_q <= sat_size;
			limit_q    <= sat_limit;
			free_q     <= sat_size;
			min_q      <= sat_size;
			top_q      <= '0;
		end else if (cmd.commit) begin
			free_q <= free_d;
			min_q  <= min_d;
			top_q  <= top_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data <= {{PAD_W{1'b0}}, free_d, idx_out, status};
		end
	end

	// Free stack body, slots 1 and up
	fnpa_ram #(
		.WIDTH (AW),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (quot[AW-1:0]),
		.re    (cmd.load),
		.raddr (rd_pos[AW-1:0]),
		.rdata (ram_rdata)
	);

endmodule

// ===== rtl/fixed_node_pool_allocator.sv =====
// ---------------------------------------------------------------------------
// fixed_node_pool_allocator: fixed-size node pool with a free-index stack
// Leases and releases node indices; reports status and free count.
// ---------------------------------------------------------------------------
// Each request passes an accept state, which reads the stack memory and
// starts the offset quotient multiply, and an execute state, which checks
// the offset, updates the stack and loads the result register once that
// register has room. A new request is accepted only after the last one has
// committed; a result waiting in the result register does not block the
// next accept, only its commit. The registered read of the stack memory,
// needed before the stack update, is why a request needs the execute state.
// No clearing pass is needed after reset or a capacity write: untouched
// stack entries are tracked by a low-water mark of the free count. A
// capacity write of zero is ignored and larger values saturate to POOL_DEPTH.
module fixed_node_pool_allocator #(
	parameter int POOL_DEPTH = fnpa_pkg::DEF_POOL_DEPTH,
	parameter int NODE_BYTES = fnpa_pkg::DEF_NODE_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// capacity write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fnpa_pkg::POOL_CAP_W-1:0]  cfg_data,
	// request stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [fnpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] node_offset
	input  logic [fnpa_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // [0] req_type
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [fnpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [2:0] status,
	                                                       // [10:3] node_index,
	                                                       // [19:11] free_count
);
	import fnpa_pkg::*;

	fnpa_cmd_t cmd;

	// Sequencing
	fnpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// Stack and checks
	fnpa_dp #(
		.POOL_DEPTH (POOL_DEPTH),
		.NODE_BYTES (NODE_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg_data (cfg_data),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.out_data (m_axis_tdata)
	);

endmodule

// ===== rtl/fnpa_checker.sv =====
// ---------------------------------------------------------------------------
// fnpa_checker: port-level checks of the fixed node pool allocator
// Watches the streams and flags results that cannot occur.
// ---------------------------------------------------------------------------
module fnpa_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [fnpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import fnpa_pkg::*;

	logic [STATUS_W-1:0]     st;
	logic [NODE_INDEX_W-1:0] idx;
	logic [FREE_COUNT_W-1:0] cnt;

	assign st  = m_axis_tdata[STATUS_W-1:0];
	assign idx = m_axis_tdata[STATUS_W +: NODE_INDEX_W];
	assign cnt = m_axis_tdata[STATUS_W + NODE_INDEX_W +: FREE_COUNT_W];

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// An accepted request moves the block to its execute state, where it takes no request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted in execute cycle");

	// Index is zero unless the request succeeded
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (st != ST_OK) |-> idx == '0)
		else $error("node index set on failed request");

	// Empty status only when nothing is free
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (st == ST_EMPTY) |-> cnt == '0)
		else $error("empty status with free nodes");

endmodule

bind fixed_node_pool_allocator fnpa_checker u_fnpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
